### design/insort_pkg.sv
// Shared types and constants for the insertion sorter.
package insort_pkg;

  // Width of one data word.
  localparam int unsigned DataW = 32;

  // Default number of cells in the sorting chain.
  localparam int unsigned MaxElementsDef = 16;

  // Controller phases: collecting a set, then draining it.
  typedef enum logic {
    StFill,
    StDrain
  } state_e;

  // Per-cell control, built by the top level from the fill count.
  typedef struct packed {
    logic ins;       // a new key is being inserted this cycle
    logic shift;     // the chain moves one place toward cell zero
    logic occupied;  // this cell holds a word of the current set
    logic tail;      // this cell is the first free one
  } cell_ctrl_t;

endpackage

### design/insort_cell.sv
// One cell of the systolic sorting chain: holds one word of the sorted set.
module insort_cell (
  input  logic                                 clk_i,
  input  insort_pkg::cell_ctrl_t               ctrl_i,
  input  logic signed [insort_pkg::DataW-1:0]  key_i,
  input  logic signed [insort_pkg::DataW-1:0]  left_value_i,
  input  logic                                 left_gt_i,
  input  logic signed [insort_pkg::DataW-1:0]  right_value_i,
  output logic signed [insort_pkg::DataW-1:0]  value_o,
  output logic                                 gt_o
);
  import insort_pkg::*;

  logic signed [DataW-1:0] value_q, value_d;

  // A stored word strictly larger than the key has to move up one place.
  assign gt_o    = ctrl_i.occupied && (value_q > key_i);
  assign value_o = value_q;

  // Insert: take the left neighbor's word if it moves up too, else the key.
  // Drain: take the right neighbor's word.
  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins && (gt_o || ctrl_i.tail)) begin
      value_d = left_gt_i ? left_value_i : key_i;
    end else if (ctrl_i.shift) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

### design/insort_ctrl.sv
// Controller of the insertion sorter: fill count, drop flag and handshakes.
module insort_ctrl #(
  parameter int unsigned MaxElements = insort_pkg::MaxElementsDef,
  parameter int unsigned CntW        = $clog2(MaxElements + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            last_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            last_res_o,
  output logic            overflow_o,
  output logic            ins_o,
  output logic            shift_o,
  output logic [CntW-1:0] fill_o
);
  import insort_pkg::*;

  localparam logic [CntW-1:0] FullCnt = CntW'(MaxElements);
  localparam logic [CntW-1:0] OneCnt  = CntW'(1);

  state_e          state_q, state_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            dropped_q, dropped_d;
  logic            in_acc, out_acc, full;

  assign full    = (fill_q == FullCnt);
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StFill:  if (in_acc && last_i) state_d = StDrain;
      StDrain: if (out_acc && (fill_q == OneCnt)) state_d = StFill;
      default: state_d = StFill;
    endcase
  end

  // Handshake and chain control outputs.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StFill:  in_ready_o  = 1'b1;
      StDrain: out_valid_o = 1'b1;
      default: in_ready_o  = 1'b0;
    endcase
  end

  assign ins_o      = in_acc && !full;
  assign shift_o    = out_acc;
  assign last_res_o = (fill_q == OneCnt);
  assign overflow_o = dropped_q;
  assign fill_o     = fill_q;

  // Fill count and drop flag.
  always_comb begin
    fill_d    = fill_q;
    dropped_d = dropped_q;
    if (ins_o) begin
      fill_d = fill_q + OneCnt;
    end else if (in_acc) begin
      dropped_d = 1'b1;
    end
    if (out_acc) begin
      fill_d = fill_q - OneCnt;
      if (fill_q == OneCnt) begin
        dropped_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StFill;
      fill_q    <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      dropped_q <= dropped_d;
    end
  end

  // The fill count never passes the chain length.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FullCnt)
    else $error("fill count beyond chain length");

  // A set being drained always has at least one word left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDrain) |-> (fill_q != '0))
    else $error("drain with empty chain");

  // After the final word leaves, the chain is empty and the flag is clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_res_o) |=> (fill_q == '0 && !dropped_q && state_q == StFill))
    else $error("set did not end cleanly");

  // A word arriving at a full chain raises the drop flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && full) |=> dropped_q)
    else $error("drop not flagged");

endmodule

### design/insertion_sorter.sv
// Insertion sorter top level: chain of compare-and-shift cells plus controller.
//
// The input channel (in_valid_i/in_ready_o) takes one signed word per cycle,
// value_i, with last_i marking the final word of a set. Every cell compares
// its stored word with the incoming key at once, and all words strictly
// larger than the key move up one cell, so equal words keep arrival order.
// Words arriving when all MaxElements cells are full are dropped and overflow_o
// is raised on every result of that set. After the last word is accepted the
// block drains: the output channel (out_valid_o/out_ready_i) presents the set
// in ascending order starting the next cycle, one word per cycle while
// out_ready_i is high, with last_res_o on the final one. The chain shifts
// toward cell zero each time a word is taken. In_ready_o is low while
// draining. A stalled receiver simply holds the chain and the current word.
// Reset empties the chain and clears the drop flag; stored words need no
// clearing since only filled cells are ever read.
module insertion_sorter #(
  parameter int unsigned MaxElements = insort_pkg::MaxElementsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [insort_pkg::DataW-1:0]  value_i,
  input  logic                                 last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [insort_pkg::DataW-1:0]  sorted_value_o,
  output logic                                 last_res_o,
  output logic                                 overflow_o
);
  import insort_pkg::*;

  localparam int unsigned CntW = $clog2(MaxElements + 1);

  logic                    ins, shift;
  logic [CntW-1:0]         fill;
  logic signed [DataW-1:0] cell_value [MaxElements];
  logic                    cell_gt    [MaxElements];

  insort_ctrl #(
    .MaxElements(MaxElements),
    .CntW       (CntW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .last_res_o (last_res_o),
    .overflow_o (overflow_o),
    .ins_o      (ins),
    .shift_o    (shift),
    .fill_o     (fill)
  );

  // Row of cells; each sees its left and right neighbor.
  for (genvar i = 0; i < MaxElements; i++) begin : g_cell
    logic signed [DataW-1:0] left_value, right_value;
    logic                    left_gt;
    cell_ctrl_t              ctrl;

    // Cell control derived from the fill count.
    always_comb begin
      ctrl.ins      = ins;
      ctrl.shift    = shift;
      ctrl.occupied = (CntW'(i) < fill);
      ctrl.tail     = (CntW'(i) == fill);
    end

    if (i == 0) begin : g_first
      assign left_value = value_i;
      assign left_gt    = 1'b0;
    end else begin : g_inner
      assign left_value = cell_value[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == MaxElements - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_body
      assign right_value = cell_value[i+1];
    end

    insort_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .key_i        (value_i),
      .left_value_i (left_value),
      .left_gt_i    (left_gt),
      .right_value_i(right_value),
      .value_o      (cell_value[i]),
      .gt_o         (cell_gt[i])
    );
  end

  // The smallest remaining word always sits in cell zero.
  assign sorted_value_o = cell_value[0];

endmodule

### tb/testbench.sv
// Self-checking testbench for the insertion sorter with bursty input and stalled output.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import insort_pkg::*;

  localparam int Cells       = MaxElementsDef;
  localparam int RandomWords = 380;
  localparam int IdleLimit   = 4000;
  localparam int DrainCycles = 40;
  localparam int HoldCycles  = 400;

  typedef logic signed [DataW-1:0] word_val_t;

  typedef struct {
    word_val_t value;
    logic      last;
  } in_word_t;

  typedef struct {
    word_val_t value;
    logic      last;
    logic      overflow;
  } sorted_word_t;

  logic      clk       = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  word_val_t value     = '0;
  logic      last      = 1'b0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  word_val_t sorted_value;
  logic      last_res;
  logic      overflow;

  // Words waiting to be sent and sorted words still to arrive.
  in_word_t     pending_words[$];
  sorted_word_t sorted_expect[$];

  // Predicted contents of the sorting chain for the set being collected.
  word_val_t sort_store[Cells];
  int        set_count   = 0;
  logic      set_dropped = 1'b0;

  logic in_fire      = 1'b0;
  int   error_count  = 0;
  int   results_seen = 0;
  int   idle_cycles  = 0;

  // Sender and receiver pacing state.
  int burst_left    = 0;
  int gap_left      = 0;
  int rx_mode       = 0;
  int mode_left     = 0;
  int hold_left     = 0;
  bit pressure_done = 1'b0;

  insertion_sorter dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .value_i       (value),
    .last_i        (last),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .sorted_value_o(sorted_value),
    .last_res_o    (last_res),
    .overflow_o    (overflow)
  );

  always #2 clk = ~clk;

  task automatic add_word(input word_val_t v, input logic is_last);
    in_word_t w;
    w.value = v;
    w.last  = is_last;
    pending_words.push_back(w);
  endtask

  // Mix of full-range values, small values that repeat often, and the extremes.
  function automatic word_val_t pick_value();
    int small_v;
    small_v = $urandom_range(0, 8);
    case ($urandom_range(0, 5))
      0, 1: pick_value = small_v - 4;
      2: begin
        case ($urandom_range(0, 3))
          0: pick_value = 32'sh7fff_ffff;
          1: pick_value = 32'sh8000_0000;
          2: pick_value = -1;
          default: pick_value = 0;
        endcase
      end
      default: pick_value = $urandom;
    endcase
  endfunction

  // Insert one accepted word; at the end of a set queue the whole sorted run.
  task automatic predict_word(input word_val_t key, input logic is_last);
    int           pos;
    sorted_word_t res;
    if (set_count < Cells) begin
      pos = set_count;
      while (pos > 0 && sort_store[pos-1] > key) begin
        sort_store[pos] = sort_store[pos-1];
        pos--;
      end
      sort_store[pos] = key;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (is_last) begin
      for (int k = 0; k < set_count; k++) begin
        res.value    = sort_store[k];
        res.last     = (k == set_count - 1);
        res.overflow = set_dropped;
        sorted_expect.push_back(res);
      end
      set_count   = 0;
      set_dropped = 1'b0;
    end
  endtask

  task automatic note_mismatch(input string what, input longint want_v, input longint got_v);
    error_count++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    in_word_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        nxt = pending_words.pop_front();
        in_valid <= 1'b1;
        value    <= nxt.value;
        last     <= nxt.last;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: switches between always ready, random and mostly stalled, and once
  // holds off long enough for the sorter to back up its input.
  always @(negedge clk) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!pressure_done && results_seen >= 30 && in_valid) begin
      pressure_done = 1'b1;
      hold_left     = HoldCycles;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
      if (mode_left != 0) begin
        mode_left--;
      end else begin
        rx_mode   = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 60);
      end
    end
  end

  // Monitor: predict on accepted input words, check every accepted sorted word.
  always @(posedge clk) begin
    sorted_word_t want;
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        predict_word(value, last);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (sorted_expect.size() == 0) begin
          error_count++;
          $display("%0t: sorted word mismatch, expected none, got %0d", $time, sorted_value);
        end else begin
          want = sorted_expect.pop_front();
          if (sorted_value !== want.value) note_mismatch("sorted_value", want.value, sorted_value);
          if (last_res !== want.last) note_mismatch("last_res", want.last, last_res);
          if (overflow !== want.overflow) note_mismatch("overflow", want.overflow, overflow);
        end
      end
      // Watchdog on cycles with no word moving on either side.
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int len;
    // A single-word set, a set with the extremes, then a set that overflows on its last word.
    add_word(32'sh8000_0000, 1'b1);
    add_word(32'sh7fff_ffff, 1'b0);
    add_word(32'sh8000_0000, 1'b0);
    add_word(-1, 1'b0);
    add_word(0, 1'b0);
    add_word(1, 1'b1);
    for (int k = 0; k <= Cells; k++) begin
      add_word(1000 - 37 * k, k == Cells);
    end
    // Random sets, mostly within the chain size, some full, some overflowing.
    while (pending_words.size() < RandomWords + Cells + 7) begin
      case ($urandom_range(0, 9))
        0: len = $urandom_range(Cells + 1, Cells + 4);
        1: len = Cells;
        2: len = 1;
        default: len = $urandom_range(2, Cells - 1);
      endcase
      for (int k = 0; k < len; k++) begin
        add_word(pick_value(), k == len - 1);
      end
    end

    repeat (12) @(negedge clk);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || in_valid || sorted_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);

    if (error_count == 0 && sorted_expect.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
